// ----- sv/tnmh_pkg.sv -----
// shared types and constants for the top-n min-heap keeper
package tnmh_pkg;

   localparam int unsigned KEEP_W = 6;
   localparam int unsigned RANK_W = 5;
   localparam int unsigned RESULT_LIMIT = 32;

   localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd16;

   localparam logic OP_OFFER = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] amplitude;
   } entry_type;

   typedef struct packed {
      logic               op;
      logic signed [31:0] position;
      logic signed [31:0] amplitude;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_position;
      logic signed [31:0] out_amplitude;
      logic [RANK_W-1:0]  rank;
      logic               is_last;
   } rsp_type;

endpackage

// ----- sv/tnmh_ram.sv -----
// generic single-write, single-read ram with registered read data
module tnmh_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 32,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/top_n_min_heap_keeper.sv -----
// top-n keeper: min-heap by amplitude held in one ram, sift walks over it
//
//  channel  ports                         transfer
//  request  start, busy, req_data         start high and busy low at a clock edge
//  result   rsp_strobe, rsp_data          every cycle rsp_strobe is high
//  config   csr_wr_en, csr_wr_data        every cycle csr_wr_en is high
//
// an insert reads one parent per level on sift-up, a replace two children per level on
// sift-down, all through the one read port of the heap ram
// a drain pops the root and sifts down until the heap is empty, busy held throughout
// synchronous reset empties the heap (occupancy zero) with no clearing pass
// results are never stalled: each one is shown for a single cycle
module top_n_min_heap_keeper
   import tnmh_pkg::*;
#(
   parameter int unsigned HEAP_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [KEEP_W-1:0] csr_wr_data
);

   localparam int unsigned IDX_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int unsigned CAP_LIM = (HEAP_DEPTH < RESULT_LIMIT) ? HEAP_DEPTH : RESULT_LIMIT;
   localparam int unsigned CNT_W = $clog2(CAP_LIM + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROOT_WAIT,
      S_UP_RD,
      S_UP_CMP,
      S_FIN,
      S_DN_RDL,
      S_DN_RDR,
      S_DN_CMP,
      S_DR_RD,
      S_DR_TOP,
      S_DR_LAST
   } state_type;

   state_type         state_ff;
   logic              drain_ff;
   entry_type         e_ff;
   entry_type         left_ff;
   logic              rvalid_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  occ_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [RANK_W-1:0] rank_ff;
   logic [KEEP_W-1:0] keep_ff;
   logic              rsp_strobe_ff;
   rsp_type           rsp_data_ff;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   entry_type         ram_wdata;
   logic [IDX_W-1:0]  ram_raddr;
   logic [63:0]       ram_rdata;
   entry_type         rd_entry;

   logic [KEEP_W-1:0] cap;
   logic              has_room;
   logic [7:0]        l_ext;
   logic [7:0]        r_ext;
   logic              l_ok;
   logic              r_ok;
   logic [IDX_W-1:0]  parent_idx;
   logic [IDX_W-1:0]  last_idx;
   logic              pick_r;
   entry_type         child;
   logic [IDX_W-1:0]  child_idx;
   logic              up_move;
   logic              dn_move;

   tnmh_ram #(
      .WIDTH (64),
      .DEPTH (HEAP_DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_entry = entry_type'(ram_rdata);

   always_comb begin
      if (keep_ff == '0) begin
         cap = KEEP_W'(1);
      end else if (7'(keep_ff) > 7'(CAP_LIM)) begin
         cap = KEEP_W'(CAP_LIM);
      end else begin
         cap = keep_ff;
      end
   end

   assign has_room   = 7'(occ_ff) < 7'(cap);
   assign l_ext      = 8'({idx_ff, 1'b1});
   assign r_ext      = l_ext + 8'd1;
   assign l_ok       = l_ext < 8'(cnt_ff);
   assign r_ok       = r_ext < 8'(cnt_ff);
   assign parent_idx = (idx_ff - IDX_W'(1)) >> 1;
   assign last_idx   = IDX_W'(occ_ff - CNT_W'(1));
   assign pick_r     = rvalid_ff && (rd_entry.amplitude < left_ff.amplitude);
   assign child      = pick_r ? rd_entry : left_ff;
   assign child_idx  = pick_r ? r_ext[IDX_W-1:0] : l_ext[IDX_W-1:0];
   assign up_move    = rd_entry.amplitude > e_ff.amplitude;
   assign dn_move    = child.amplitude < e_ff.amplitude;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = e_ff;
      ram_raddr = '0;
      case (state_ff)
         S_UP_RD: begin
            ram_raddr = parent_idx;
         end
         S_UP_CMP: begin
            ram_we = 1'b1;
            if (up_move) begin
               ram_wdata = rd_entry;
            end
         end
         S_FIN: begin
            ram_we = 1'b1;
         end
         S_DN_RDL: begin
            ram_raddr = l_ext[IDX_W-1:0];
            ram_we    = !l_ok;
         end
         S_DN_RDR: begin
            ram_raddr = r_ext[IDX_W-1:0];
         end
         S_DN_CMP: begin
            ram_we = 1'b1;
            if (dn_move) begin
               ram_wdata = child;
            end
         end
         S_DR_TOP: begin
            ram_raddr = last_idx;
         end
         default: begin
            ram_raddr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         drain_ff      <= 1'b0;
         occ_ff        <= '0;
         rank_ff       <= '0;
         keep_ff       <= KEEP_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_wr_en) begin
            keep_ff <= csr_wr_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  e_ff <= '{position: req_data.position, amplitude: req_data.amplitude};
                  if (req_data.op == OP_DRAIN) begin
                     drain_ff <= 1'b1;
                     rank_ff  <= '0;
                     if (occ_ff != '0) begin
                        state_ff <= S_DR_TOP;
                     end
                  end else begin
                     drain_ff <= 1'b0;
                     if (has_room) begin
                        idx_ff <= IDX_W'(occ_ff);
                        occ_ff <= occ_ff + CNT_W'(1);
                        state_ff <= (occ_ff == '0) ? S_FIN : S_UP_RD;
                     end else begin
                        state_ff <= S_ROOT_WAIT;
                     end
                  end
               end
            end
            S_ROOT_WAIT: begin
               if (e_ff.amplitude > rd_entry.amplitude) begin
                  idx_ff   <= '0;
                  cnt_ff   <= occ_ff;
                  state_ff <= S_DN_RDL;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_UP_RD: begin
               state_ff <= S_UP_CMP;
            end
            S_UP_CMP: begin
               if (up_move) begin
                  idx_ff   <= parent_idx;
                  state_ff <= (parent_idx == '0) ? S_FIN : S_UP_RD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_FIN: begin
               state_ff <= S_IDLE;
            end
            S_DN_RDL: begin
               if (l_ok) begin
                  state_ff <= S_DN_RDR;
               end else begin
                  state_ff <= drain_ff ? S_DR_RD : S_IDLE;
               end
            end
            S_DN_RDR: begin
               left_ff   <= rd_entry;
               rvalid_ff <= r_ok;
               state_ff  <= S_DN_CMP;
            end
            S_DN_CMP: begin
               if (dn_move) begin
                  idx_ff   <= child_idx;
                  state_ff <= S_DN_RDL;
               end else begin
                  state_ff <= drain_ff ? S_DR_RD : S_IDLE;
               end
            end
            S_DR_RD: begin
               state_ff <= S_DR_TOP;
            end
            S_DR_TOP: begin
               rsp_strobe_ff <= 1'b1;
               rsp_data_ff   <= '{out_position: rd_entry.position,
                                  out_amplitude: rd_entry.amplitude,
                                  rank: rank_ff,
                                  is_last: (occ_ff == CNT_W'(1))};
               rank_ff <= rank_ff + RANK_W'(1);
               if (occ_ff == CNT_W'(1)) begin
                  occ_ff   <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_DR_LAST;
               end
            end
            S_DR_LAST: begin
               e_ff     <= rd_entry;
               occ_ff   <= occ_ff - CNT_W'(1);
               cnt_ff   <= occ_ff - CNT_W'(1);
               idx_ff   <= '0;
               state_ff <= S_DN_RDL;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      7'(occ_ff) <= 7'(CAP_LIM))
      else $error("occupancy beyond capacity limit");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.is_last |-> occ_ff == '0)
      else $error("last drain transfer with entries left");

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.is_last |-> busy && occ_ff != '0)
      else $error("drain stopped before last transfer");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> occ_ff == $past(occ_ff) || occ_ff == $past(occ_ff) + CNT_W'(1)
         || occ_ff == $past(occ_ff) - CNT_W'(1))
      else $error("occupancy moved by more than one");

   a_drain_only_out: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(drain_ff))
      else $error("result outside a drain");
`endif

endmodule

// ----- dv/heap_keeper_scoreboard.sv -----
// scoreboard for the top-n keeper: mirrors the heap and checks every drained entry
module heap_keeper_scoreboard
   import tnmh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  req_type           req_data,
   input  logic              rsp_strobe,
   input  rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [KEEP_W-1:0] csr_wr_data,
   output int                fail_count,
   output int                pending_pops,
   output int                pops_seen
);

   localparam int unsigned DEPTH = 32;

   entry_type         heap_slots [DEPTH];
   int unsigned       heap_fill;
   logic [KEEP_W-1:0] keep_reg;
   rsp_type           expected_pops [$];
   int                fails;
   int                seen;

   function automatic bit amp_less(entry_type a, entry_type b);
      return $signed(a.amplitude) < $signed(b.amplitude);
   endfunction

   function automatic void swap_slots(int unsigned a, int unsigned b);
      entry_type t;
      t = heap_slots[a];
      heap_slots[a] = heap_slots[b];
      heap_slots[b] = t;
   endfunction

   // left child wins a tie between children
   function automatic void sink_root(int unsigned count);
      int unsigned idx;
      int unsigned l;
      int unsigned r;
      int unsigned best;
      bit          done;
      idx = 0;
      done = 1'b0;
      while (!done) begin
         l = 2 * idx + 1;
         r = l + 1;
         best = idx;
         if (l < count && amp_less(heap_slots[l], heap_slots[best])) best = l;
         if (r < count && amp_less(heap_slots[r], heap_slots[best])) best = r;
         if (best == idx) begin
            done = 1'b1;
         end else begin
            swap_slots(idx, best);
            idx = best;
         end
      end
   endfunction

   function automatic void apply_request(req_type item);
      int unsigned cap;
      int unsigned idx;
      int unsigned parent;
      int unsigned rank;
      bit          climbing;
      entry_type   fresh;
      rsp_type     pop;
      cap = (keep_reg == 0) ? 1 : ((keep_reg > DEPTH) ? DEPTH : keep_reg);
      if (item.op == OP_OFFER) begin
         fresh.position = item.position;
         fresh.amplitude = item.amplitude;
         if (heap_fill < cap) begin
            heap_slots[heap_fill] = fresh;
            idx = heap_fill;
            climbing = 1'b1;
            while (idx > 0 && climbing) begin
               parent = (idx - 1) / 2;
               if (amp_less(heap_slots[idx], heap_slots[parent])) begin
                  swap_slots(idx, parent);
                  idx = parent;
               end else begin
                  climbing = 1'b0;
               end
            end
            heap_fill++;
         end else if (heap_fill > 0 && amp_less(heap_slots[0], fresh)) begin
            heap_slots[0] = fresh;
            sink_root(heap_fill);
         end
      end else begin
         rank = 0;
         while (heap_fill > 0) begin
            pop.out_position = heap_slots[0].position;
            pop.out_amplitude = heap_slots[0].amplitude;
            heap_fill--;
            heap_slots[0] = heap_slots[heap_fill];
            sink_root(heap_fill);
            pop.rank = rank[RANK_W-1:0];
            pop.is_last = (heap_fill == 0);
            expected_pops.push_back(pop);
            rank++;
         end
      end
   endfunction

   function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
      $display("%0t  %s expected %h got %h", $time, name, want, got);
   endfunction

   function automatic void check_pop(rsp_type got);
      rsp_type want;
      bit      bad;
      seen++;
      if (expected_pops.size() == 0) begin
         $display("%0t  result transfer expected none got %h", $time, got);
         fails++;
         return;
      end
      want = expected_pops.pop_front();
      bad = 1'b0;
      if (got.out_position !== want.out_position) begin
         report_field("out_position", want.out_position, got.out_position);
         bad = 1'b1;
      end
      if (got.out_amplitude !== want.out_amplitude) begin
         report_field("out_amplitude", want.out_amplitude, got.out_amplitude);
         bad = 1'b1;
      end
      if (got.rank !== want.rank) begin
         report_field("rank", 32'(want.rank), 32'(got.rank));
         bad = 1'b1;
      end
      if (got.is_last !== want.is_last) begin
         report_field("is_last", 32'(want.is_last), 32'(got.is_last));
         bad = 1'b1;
      end
      if (bad) fails++;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         heap_fill = 0;
         keep_reg = KEEP_RESET;
         expected_pops.delete();
      end else begin
         if (rsp_strobe) check_pop(rsp_data);
         if (csr_wr_en) keep_reg = csr_wr_data;
         if (start && !busy) apply_request(req_data);
      end
      fail_count <= fails;
      pending_pops <= expected_pops.size();
      pops_seen <= seen;
   end

endmodule

// ----- dv/tb_top_n_min_heap_keeper.sv -----
// testbench top: drives offers, drains and keep_count writes, and gives the verdict
module tb_top_n_min_heap_keeper;
   import tnmh_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_strobe;
   rsp_type           rsp_data;
   logic              csr_wr_en;
   logic [KEEP_W-1:0] csr_wr_data;

   int fail_count;
   int pending_pops;
   int pops_seen;
   int cycle_count;
   int sent_count;
   int keep_writes;
   bit idle_on;

   top_n_min_heap_keeper dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   heap_keeper_scoreboard scoreboard (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .pending_pops (pending_pops),
      .pops_seen    (pops_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d entries outstanding", pending_pops);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // holds start high across back-to-back transfers
   task automatic push_request(logic op, logic [31:0] pos, logic [31:0] amp);
      req_type item;
      int      gap;
      if (idle_on && $urandom_range(99) < 9) begin
         start <= 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(posedge clock);
      end
      item.op = op;
      item.position = pos;
      item.amplitude = amp;
      req_data <= item;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_pops != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keep(logic [KEEP_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      keep_writes++;
   endtask

   function automatic logic [31:0] pick_amp(int unsigned mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(8) - 4;
         2: return ($urandom_range(20) - 10) << 16;
         default: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   initial begin
      int unsigned i;
      int unsigned offers;
      int unsigned mode;
      int unsigned keep_pick;
      int unsigned phase_count;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      idle_on = 1'b1;
      phase_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset keep_count, drain of an empty heap, field extremes and ties
      push_request(OP_DRAIN, 32'h0, 32'h0);
      push_request(OP_OFFER, 32'h7fff_ffff, 32'h8000_0000);
      push_request(OP_OFFER, 32'h8000_0000, 32'h7fff_ffff);
      push_request(OP_OFFER, 32'h0000_0000, 32'h0000_0000);
      push_request(OP_OFFER, 32'hffff_ffff, 32'hffff_ffff);
      push_request(OP_OFFER, 32'h0000_0005, 32'h0001_0000);
      push_request(OP_OFFER, 32'h0000_0006, 32'h0001_0000);
      push_request(OP_OFFER, 32'h0000_0007, 32'hffff_ffff);
      push_request(OP_DRAIN, 32'hffff_ffff, 32'hffff_ffff);

      // zero keep acts as one, an equal amplitude leaves the root
      settle();
      write_keep('0);
      push_request(OP_OFFER, 32'h1, 32'd10);
      push_request(OP_OFFER, 32'h2, 32'd10);
      push_request(OP_OFFER, 32'h3, 32'd11);
      push_request(OP_OFFER, 32'h4, 32'd5);
      push_request(OP_DRAIN, 32'h0, 32'h0);

      // keep lowered below occupancy drops no entries, a larger offer replaces the root
      settle();
      write_keep(6'd8);
      for (i = 0; i < 6; i++) push_request(OP_OFFER, i, pick_amp(2));
      settle();
      write_keep(6'd2);
      push_request(OP_OFFER, 32'h100, 32'h7fff_0000);
      push_request(OP_OFFER, 32'h101, 32'h8000_0001);
      push_request(OP_DRAIN, 32'h0, 32'h0);

      while (sent_count < 380) begin
         settle();
         case ($urandom_range(5))
            0: keep_pick = 0;
            1: keep_pick = 1;
            2: keep_pick = 32;
            3: keep_pick = 63;
            default: keep_pick = $urandom_range(2, 12);
         endcase
         write_keep(keep_pick[KEEP_W-1:0]);
         mode = $urandom_range(3);
         offers = $urandom_range(1, 40);
         idle_on = (phase_count < 4 || phase_count > 7);
         for (i = 0; i < offers; i++) begin
            if ($urandom_range(39) == 0) begin
               push_request(OP_DRAIN, $urandom, $urandom);
            end else if ($urandom_range(59) == 0) begin
               settle();
               write_keep(KEEP_W'($urandom_range(63)));
            end
            push_request(OP_OFFER, $urandom, pick_amp(mode));
         end
         push_request(OP_DRAIN, $urandom, $urandom);
         phase_count++;
      end

      settle();
      $display("ran %0d offer and drain transfers over %0d keep_count writes", sent_count,
               keep_writes);
      $display("checked %0d drained entries in %0d cycles", pops_seen, cycle_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- top_n_min_heap_keeper.f -----
sv/tnmh_pkg.sv
sv/tnmh_ram.sv
sv/top_n_min_heap_keeper.sv
dv/heap_keeper_scoreboard.sv
dv/tb_top_n_min_heap_keeper.sv
